// File: sv/dllq_pkg.sv
// ----------------------------------------------------------------------------
// dllq_pkg
// Shared types and fixed field widths for the linked-list cursor queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dllq_pkg;

  // Fixed stream field widths
  localparam int ACTION_BITS      = 3;
  localparam int HANDLE_IN_BITS   = 16;
  localparam int HANDLE_OUT_BITS  = 16;
  localparam int ENTRY_COUNT_BITS = 7;
  localparam int S_TDATA_BITS     = 24;
  localparam int M_TDATA_BITS     = 32;

  // Operation codes carried in the low bits of each input item
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_APPEND     = 3'd0,
    ACT_PEEK_FIRST = 3'd1,
    ACT_POP_FIRST  = 3'd2,
    ACT_CUR_FIRST  = 3'd3,
    ACT_CUR_ADV    = 3'd4,
    ACT_CUR_READ   = 3'd5,
    ACT_CUR_REMOVE = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Write enables into the slot store
  typedef struct packed {
    logic payload;
    logic fwd;
    logic bwd;
  } store_we_t;

  // Commands into the free-slot pool
  typedef struct packed {
    logic rd;
    logic alloc;
    logic release_slot;
  } pool_cmd_t;

endpackage

`default_nettype wire

// File: sv/dllq_slot_store.sv
// ----------------------------------------------------------------------------
// dllq_slot_store
// Payload, forward-link and backward-link memories, one shared read address.
// ----------------------------------------------------------------------------
`default_nettype none

module dllq_slot_store #(
  parameter int SLOT_COUNT = 64,
  parameter int DATA_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] rd_addr,
  output logic      [DATA_BITS-1:0]          rd_payload,
  output logic      [$clog2(SLOT_COUNT)-1:0] rd_fwd,
  output logic      [$clog2(SLOT_COUNT)-1:0] rd_bwd,
  input  wire dllq_pkg::store_we_t           we,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] pl_addr,
  input  wire logic [DATA_BITS-1:0]          pl_data,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] fw_addr,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] fw_data,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] bw_addr,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] bw_data
);

  localparam int IW = $clog2(SLOT_COUNT);

  logic [DATA_BITS-1:0] payload_mem [SLOT_COUNT];
  logic [IW-1:0]        fwd_mem     [SLOT_COUNT];
  logic [IW-1:0]        bwd_mem     [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we.payload) begin
      payload_mem[pl_addr] <= pl_data;
    end
    if (rd_en) begin
      rd_payload <= payload_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we.fwd) begin
      fwd_mem[fw_addr] <= fw_data;
    end
    if (rd_en) begin
      rd_fwd <= fwd_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we.bwd) begin
      bwd_mem[bw_addr] <= bw_data;
    end
    if (rd_en) begin
      rd_bwd <= bwd_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/dllq_free_pool.sv
// ----------------------------------------------------------------------------
// dllq_free_pool
// Free-slot allocator: a stack of released slots in memory, backed by a
// counter that hands out never-used slots in order.
// ----------------------------------------------------------------------------
`default_nettype none

module dllq_free_pool #(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dllq_pkg::pool_cmd_t           cmd,
  input  wire logic [$clog2(SLOT_COUNT)-1:0] release_addr,
  output logic      [$clog2(SLOT_COUNT)-1:0] alloc_addr
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(SLOT_COUNT + 1);

  logic [IW-1:0] stack_mem [SLOT_COUNT];
  logic [IW-1:0] stack_q;
  logic [LW-1:0] sp;
  logic [LW-1:0] sp_m1;
  logic [LW-1:0] fresh;

  assign sp_m1      = sp - LW'(1);
  assign alloc_addr = (sp != '0) ? stack_q : fresh[IW-1:0];

  // Prefetch the top of stack in the read cycle
  always_ff @(posedge clk) begin
    if (cmd.release_slot) begin
      stack_mem[sp[IW-1:0]] <= release_addr;
    end
    if (cmd.rd) begin
      stack_q <= stack_mem[sp_m1[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp    <= '0;
      fresh <= '0;
    end else if (cmd.release_slot) begin
      sp <= sp + LW'(1);
    end else if (cmd.alloc) begin
      if (sp != '0) begin
        sp <= sp_m1;
      end else begin
        fresh <= fresh + LW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/doubly_linked_list_cursor_queue.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_queue
// Ordered list of handles in a slot store with links, head, tail and cursor.
// ----------------------------------------------------------------------------
// Each input item carries one operation: append a handle at the tail, peek
// the first entry, remove the first entry, move the cursor to the first
// entry, advance the cursor, read at the cursor, or remove at the cursor
// (the cursor then moves to the next entry). Every item gives exactly one
// result item with the handle found, the cursor state and entry count after
// the operation, and an overflow flag for an append dropped on a full store.
// An item goes through a read cycle that fetches the addressed slot's
// payload and links from the slot memories plus the free-slot stack top, and
// a write cycle that updates links, pointers and the result register. The
// write cycle waits while a previous result is still held on the master side,
// but the next item is taken as soon as that write cycle is done. There is
// no clearing pass after reset: never-used slots come from a counter, and
// only linked slots are ever read, so slot memories need no initial value.
// A code of 7 is a no-op that reports the current cursor state and count.
// ----------------------------------------------------------------------------
`default_nettype none

module doubly_linked_list_cursor_queue #(
  parameter int SLOT_COUNT  = 64,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // action [2:0], handle_in [18:3], zero fill [23:19]
  input  wire logic [dllq_pkg::S_TDATA_BITS-1:0] s_tdata,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // handle_out [15:0], handle_valid [16], cursor_valid [17],
  // entry_count [24:18], overflow [25], zero fill [31:26]
  output logic      [dllq_pkg::M_TDATA_BITS-1:0] m_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(SLOT_COUNT + 1);
  // Handles are kept in their low bits, never wider than the input field
  localparam int StoreBits = (HANDLE_BITS < dllq_pkg::HANDLE_IN_BITS) ?
                             HANDLE_BITS : dllq_pkg::HANDLE_IN_BITS;
  localparam logic [LW-1:0] NullSlot = LW'(SLOT_COUNT);

  dllq_pkg::state_t  state;
  dllq_pkg::action_t act;
  dllq_pkg::action_t act_in;
  logic [StoreBits-1:0] handle_q;

  logic [LW-1:0] head, head_next;
  logic [LW-1:0] tail, tail_next;
  logic [LW-1:0] cursor, cursor_next;
  logic [LW-1:0] count, count_next;

  logic accept;
  logic commit;

  // slot store signals
  logic [IW-1:0]        rd_addr;
  logic [StoreBits-1:0] rd_payload;
  logic [IW-1:0]        rd_fwd;
  logic [IW-1:0]        rd_bwd;
  dllq_pkg::store_we_t  we;
  logic [IW-1:0]        pl_addr;
  logic [IW-1:0]        fw_addr, fw_data;
  logic [IW-1:0]        bw_addr, bw_data;

  // free pool signals
  dllq_pkg::pool_cmd_t pool_cmd;
  logic [IW-1:0]       release_addr;
  logic [IW-1:0]       alloc_addr;

  // links of the slot read, with the tail's forward and the head's backward
  // link taken as null whatever the memory holds
  logic [LW-1:0] head_fwd;
  logic [LW-1:0] cur_fwd;
  logic [LW-1:0] cur_bwd;

  logic                                      res_valid;
  logic                                      res_ovf;
  logic [dllq_pkg::HANDLE_OUT_BITS-1:0]      res_handle;
  logic [dllq_pkg::ENTRY_COUNT_BITS-1:0]     res_count;

  assign s_tready = (state == dllq_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  // Hold the write cycle while the result register is still occupied
  assign commit   = (state == dllq_pkg::ST_EXEC) && (!m_tvalid || m_tready);
  assign act_in   = dllq_pkg::action_t'(s_tdata[2:0]);

  assign head_fwd = (head == tail)   ? NullSlot : LW'(rd_fwd);
  assign cur_fwd  = (cursor == tail) ? NullSlot : LW'(rd_fwd);
  assign cur_bwd  = (cursor == head) ? NullSlot : LW'(rd_bwd);

  // Read address: head for peeking or popping the first entry, cursor otherwise
  always_comb begin
    case (act_in)
      dllq_pkg::ACT_PEEK_FIRST,
      dllq_pkg::ACT_POP_FIRST: rd_addr = head[IW-1:0];
      default:                 rd_addr = cursor[IW-1:0];
    endcase
  end

  always_comb begin
    head_next             = head;
    tail_next             = tail;
    cursor_next           = cursor;
    count_next            = count;
    we                    = '0;
    pool_cmd              = '0;
    pool_cmd.rd           = accept;
    pl_addr               = alloc_addr;
    fw_addr               = tail[IW-1:0];
    fw_data               = alloc_addr;
    bw_addr               = alloc_addr;
    bw_data               = tail[IW-1:0];
    release_addr          = head[IW-1:0];
    res_handle            = '0;
    res_valid             = 1'b0;
    res_ovf               = 1'b0;
    if (commit) begin
      case (act)
        dllq_pkg::ACT_APPEND: begin
          if (count == NullSlot) begin
            // Drop on a full store
            res_ovf = 1'b1;
          end else begin
            we.payload     = 1'b1;
            pool_cmd.alloc = 1'b1;
            if (tail != NullSlot) begin
              we.fwd = 1'b1;
              we.bwd = 1'b1;
            end else begin
              head_next = LW'(alloc_addr);
            end
            tail_next  = LW'(alloc_addr);
            count_next = count + LW'(1);
          end
        end
        dllq_pkg::ACT_PEEK_FIRST: begin
          if (head != NullSlot) begin
            res_handle = dllq_pkg::HANDLE_OUT_BITS'(rd_payload);
            res_valid  = 1'b1;
          end
        end
        dllq_pkg::ACT_POP_FIRST: begin
          if (head != NullSlot) begin
            res_handle = dllq_pkg::HANDLE_OUT_BITS'(rd_payload);
            res_valid  = 1'b1;
            // Move the cursor on when its entry is the one removed
            if (cursor == head) begin
              cursor_next = head_fwd;
            end
            head_next = head_fwd;
            if (head_fwd == NullSlot) begin
              tail_next = NullSlot;
            end
            pool_cmd.release_slot = 1'b1;
            release_addr          = head[IW-1:0];
            count_next            = count - LW'(1);
          end
        end
        dllq_pkg::ACT_CUR_FIRST: begin
          cursor_next = head;
        end
        dllq_pkg::ACT_CUR_ADV: begin
          if (cursor != NullSlot) begin
            cursor_next = cur_fwd;
          end
        end
        dllq_pkg::ACT_CUR_READ: begin
          if (cursor != NullSlot) begin
            res_handle = dllq_pkg::HANDLE_OUT_BITS'(rd_payload);
            res_valid  = 1'b1;
          end
        end
        dllq_pkg::ACT_CUR_REMOVE: begin
          if (cursor != NullSlot) begin
            res_handle = dllq_pkg::HANDLE_OUT_BITS'(rd_payload);
            res_valid  = 1'b1;
            // Splice the neighbors together
            if (cur_bwd != NullSlot) begin
              we.fwd  = 1'b1;
              fw_addr = cur_bwd[IW-1:0];
              fw_data = cur_fwd[IW-1:0];
            end else begin
              head_next = cur_fwd;
            end
            if (cur_fwd != NullSlot) begin
              we.bwd  = 1'b1;
              bw_addr = cur_fwd[IW-1:0];
              bw_data = cur_bwd[IW-1:0];
            end else begin
              tail_next = cur_bwd;
            end
            cursor_next           = cur_fwd;
            pool_cmd.release_slot = 1'b1;
            release_addr          = cursor[IW-1:0];
            count_next            = count - LW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_count = dllq_pkg::ENTRY_COUNT_BITS'(count_next);

  dllq_slot_store #(
    .SLOT_COUNT(SLOT_COUNT),
    .DATA_BITS (StoreBits)
  ) u_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (rd_addr),
    .rd_payload(rd_payload),
    .rd_fwd    (rd_fwd),
    .rd_bwd    (rd_bwd),
    .we        (we),
    .pl_addr   (pl_addr),
    .pl_data   (handle_q),
    .fw_addr   (fw_addr),
    .fw_data   (fw_data),
    .bw_addr   (bw_addr),
    .bw_data   (bw_data)
  );

  dllq_free_pool #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_pool (
    .clk         (clk),
    .rst         (rst),
    .cmd         (pool_cmd),
    .release_addr(release_addr),
    .alloc_addr  (alloc_addr)
  );

  // Capture the operation on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= act_in;
      handle_q <= s_tdata[StoreBits+2:3];
    end
  end

  // Sequencer and list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dllq_pkg::ST_IDLE;
      head   <= NullSlot;
      tail   <= NullSlot;
      cursor <= NullSlot;
      count  <= '0;
    end else begin
      case (state)
        dllq_pkg::ST_IDLE: begin
          if (accept) begin
            state <= dllq_pkg::ST_EXEC;
          end
        end
        dllq_pkg::ST_EXEC: begin
          if (commit) begin
            state <= dllq_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= dllq_pkg::ST_IDLE;
        end
      endcase
      if (commit) begin
        head   <= head_next;
        tail   <= tail_next;
        cursor <= cursor_next;
        count  <= count_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {6'd0, res_ovf, res_count, (cursor_next != NullSlot),
                  res_valid, res_handle};
    end
  end

  // An empty list has neither head nor tail
  a_head_count: assert property (@(posedge clk) disable iff (rst)
    (head == NullSlot) == (count == '0))
    else $error("head pointer disagrees with entry count");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (head == NullSlot) == (tail == NullSlot))
    else $error("head and tail disagree on an empty list");

  // A live cursor needs at least one entry
  a_cursor_live: assert property (@(posedge clk) disable iff (rst)
    (cursor != NullSlot) |-> (count != '0))
    else $error("cursor points into an empty list");

  // Overflow is only reported when the store was full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    res_ovf |-> (count == NullSlot) && (count_next == count))
    else $error("append dropped while slots were free");

endmodule

`default_nettype wire

// File: test/doubly_linked_list_cursor_queue_checker.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_queue_checker
// Keeps its own copy of the handle list and checks every result item.
// ----------------------------------------------------------------------------
// Every item that the block accepts is applied to a local list with a slot
// store, links, head, tail, cursor and count. The result that the item should
// give is queued. Each result item that leaves the block is compared field by
// field with the oldest queued result.
// ----------------------------------------------------------------------------

module doubly_linked_list_cursor_queue_checker
  import dllq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic [S_TDATA_BITS-1:0] s_tdata,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [M_TDATA_BITS-1:0] m_tdata,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  output int                      mismatches,
  output int                      pending
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         SLOTS   = 64;
  localparam logic [6:0] NO_SLOT = 7'd64;

  // Result fields, lowest bit last in the declaration
  typedef struct packed {
    logic                        overflow;
    logic [ENTRY_COUNT_BITS-1:0] entry_count;
    logic                        cursor_valid;
    logic                        handle_valid;
    logic [HANDLE_OUT_BITS-1:0]  handle_out;
  } list_result_t;

  logic [HANDLE_IN_BITS-1:0] handle_at [SLOTS];
  logic [6:0]                next_of   [SLOTS];
  logic [6:0]                prev_of   [SLOTS];
  logic [SLOTS-1:0]          slot_free;
  logic [6:0]                head, tail, cursor, count;

  list_result_t expected_results [$];
  list_result_t got, want;
  int           i;

  // Take a linked slot out of the list and hand it back to the free map.
  function automatic void unlink_entry(input logic [6:0] s);
    logic [6:0] p, n;
    p = prev_of[s];
    n = next_of[s];
    if (p < NO_SLOT) next_of[p] = n;
    else head = n;
    if (n < NO_SLOT) prev_of[n] = p;
    else tail = p;
    slot_free[s] = 1'b1;
    if (count != 0) count = count - 7'd1;
  endfunction

  function automatic list_result_t apply_op(input logic [ACTION_BITS-1:0] act,
                                            input logic [HANDLE_IN_BITS-1:0] h);
    list_result_t r;
    logic [6:0]   s;
    int           k;
    r = '0;
    s = NO_SLOT;
    case (act)
      ACT_APPEND: begin
        // lowest free slot wins
        for (k = SLOTS - 1; k >= 0; k--)
          if (slot_free[k]) s = 7'(k);
        if (s == NO_SLOT) begin
          r.overflow = 1'b1;
        end else begin
          slot_free[s] = 1'b0;
          handle_at[s] = h;
          next_of[s]   = NO_SLOT;
          prev_of[s]   = tail;
          if (head == NO_SLOT) head = s;
          else next_of[tail] = s;
          tail  = s;
          count = count + 7'd1;
        end
      end
      ACT_PEEK_FIRST: begin
        if (head != NO_SLOT) begin
          r.handle_out   = handle_at[head];
          r.handle_valid = 1'b1;
        end
      end
      ACT_POP_FIRST: begin
        if (head != NO_SLOT) begin
          s              = head;
          r.handle_out   = handle_at[s];
          r.handle_valid = 1'b1;
          if (cursor == s) cursor = next_of[s];
          unlink_entry(s);
        end
      end
      ACT_CUR_FIRST: cursor = head;
      ACT_CUR_ADV: begin
        if (cursor != NO_SLOT) cursor = next_of[cursor];
      end
      ACT_CUR_READ: begin
        if (cursor != NO_SLOT) begin
          r.handle_out   = handle_at[cursor];
          r.handle_valid = 1'b1;
        end
      end
      ACT_CUR_REMOVE: begin
        if (cursor != NO_SLOT) begin
          s              = cursor;
          r.handle_out   = handle_at[s];
          r.handle_valid = 1'b1;
          cursor         = next_of[s];
          unlink_entry(s);
        end
      end
      default: ;
    endcase
    r.cursor_valid = (cursor != NO_SLOT);
    r.entry_count  = count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (i = 0; i < SLOTS; i++) begin
        next_of[i] = NO_SLOT;
        prev_of[i] = NO_SLOT;
      end
      slot_free = '1;
      head      = NO_SLOT;
      tail      = NO_SLOT;
      cursor    = NO_SLOT;
      count     = '0;
      expected_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = list_result_t'(m_tdata[25:0]);
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result item %0h with nothing outstanding", m_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("handle_out", want.handle_out, got.handle_out);
          check_field("handle_valid", want.handle_valid, got.handle_valid);
          check_field("cursor_valid", want.cursor_valid, got.cursor_valid);
          check_field("entry_count", want.entry_count, got.entry_count);
          check_field("overflow", want.overflow, got.overflow);
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_op(s_tdata[2:0], s_tdata[18:3]));
    end
    pending = expected_results.size();
  end

endmodule

// File: test/doubly_linked_list_cursor_queue_test.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_queue_test
// Stimulus and verdict for the linked-list cursor queue.
// ----------------------------------------------------------------------------
// A short directed run walks the empty list, the null cursor, removal of the
// head under the cursor and handle extremes. A fill run drives the store to
// full and past it, then runs all other codes on it. Random phases follow
// with a per-phase append bias, so the list swings between empty and full,
// while the sender idles in bursts and the receiver stalls. One phase holds
// the receiver off long enough that the block backs up onto its input.
// ----------------------------------------------------------------------------

module doubly_linked_list_cursor_queue_test;

  timeunit 1ns;
  timeprecision 1ps;

  import dllq_pkg::*;

  // Spare operation code: the block treats it as a no-op
  localparam logic [ACTION_BITS-1:0] ACT_NOP = 3'd7;

  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 150;
  localparam int STORE_SLOTS   = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int WATCHDOG_TRIP = 2000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [M_TDATA_BITS-1:0] m_tdata;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;

  int mismatches;
  int pending;

  // Sender and receiver pacing, set per phase
  bit idle_on    = 1'b0;
  int burst_left = 0;
  int ready_pct  = 100;
  bit hold_req   = 1'b0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  doubly_linked_list_cursor_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  doubly_linked_list_cursor_queue_checker list_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Receiver: random ready at the phase's rate, or a long hold-off on request.
  // The hold is counted here so the sender keeps offering items meanwhile.
  always begin
    @(negedge clk);
    if (hold_req) begin
      m_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_req = 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) < ready_pct);
    end
  end

  // Watchdog: trip when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_TRIP) begin
        $display("FAIL doubly_linked_list_cursor_queue");
        $finish;
      end
    end
  end

  // Offer one operation and hold it until the block takes it. Starts and ends
  // on a falling edge; valid stays high within a burst so back-to-back items stream.
  task automatic push_op(input logic [ACTION_BITS-1:0] act,
                         input logic [HANDLE_IN_BITS-1:0] h);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (idle_on) begin
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tdata  <= {5'b0, h, act};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Mostly random handles, with the all-zero and all-one extremes mixed in.
  function automatic logic [HANDLE_IN_BITS-1:0] pick_handle();
    if ($urandom_range(9) == 0)
      return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // Append with the given weight in percent, else any other code.
  function automatic logic [ACTION_BITS-1:0] pick_op(input int append_weight);
    if ($urandom_range(99) < append_weight) return ACT_APPEND;
    return 3'($urandom_range(ACT_PEEK_FIRST, ACT_NOP));
  endfunction

  initial begin
    static int append_weight [PHASES] =
      '{50, 90, 85, 20, 60, 95, 10, 50, 70, 30, 90, 15};
    int phase;
    int k;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list and null cursor first
    push_op(ACT_PEEK_FIRST, 16'h0000);
    push_op(ACT_POP_FIRST, 16'hFFFF);
    push_op(ACT_CUR_READ, 16'h0000);
    push_op(ACT_CUR_FIRST, 16'h0000);
    push_op(ACT_CUR_ADV, 16'h0000);
    push_op(ACT_CUR_REMOVE, 16'h0000);
    push_op(ACT_NOP, 16'hFFFF);
    // handle extremes
    push_op(ACT_APPEND, 16'h0000);
    push_op(ACT_APPEND, 16'hFFFF);
    push_op(ACT_APPEND, 16'hA5A5);
    push_op(ACT_PEEK_FIRST, 16'h0000);
    push_op(ACT_CUR_FIRST, 16'h0000);
    push_op(ACT_CUR_READ, 16'h0000);
    // remove the head while the cursor sits on it: cursor moves to new head
    push_op(ACT_POP_FIRST, 16'h0000);
    push_op(ACT_CUR_READ, 16'h0000);
    push_op(ACT_CUR_ADV, 16'h0000);
    push_op(ACT_CUR_READ, 16'h0000);
    // remove the tail at the cursor: cursor falls off the end
    push_op(ACT_CUR_REMOVE, 16'h0000);
    push_op(ACT_CUR_READ, 16'h0000);
    push_op(ACT_NOP, 16'h0000);
    wait_drained();

    // Fill past capacity to get dropped appends, then run all other codes at random
    idle_on   = 1'b1;
    ready_pct = 60;
    for (k = 0; k < STORE_SLOTS + 3; k++) push_op(ACT_APPEND, pick_handle());
    for (k = 0; k < 70; k++) push_op(pick_op(0), pick_handle());
    wait_drained();

    // Random phases, each with an append bias and pacing set for it
    for (phase = 0; phase < PHASES; phase++) begin
      idle_on   = (phase % 3 != 0);
      ready_pct = (phase % 4 == 0) ? 100 : $urandom_range(30, 90);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // back the block up: receiver stops while items keep coming
        if (phase == 4 && k == 20) hold_req = 1'b1;
        push_op(pick_op(append_weight[phase]), pick_handle());
      end
      // sender pauses until everything is back
      wait_drained();
    end

    ready_pct = 100;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS doubly_linked_list_cursor_queue");
    end else begin
      $display("FAIL doubly_linked_list_cursor_queue");
    end
    $finish;
  end

endmodule
